### hw/rtl/kli_pkg.sv
// Package for the keyframe linear interpolator: sizes, mode and status codes.
// No dependencies.
package kli_pkg;
  localparam int MAX_KEYS_DEF = 16;
  localparam int NUM_CHANNELS_DEF = 9;
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [16:0] ONE_STEP = 17'd65536;
endpackage

### hw/rtl/keyframe_linear_interpolator_unit.sv
// Top level of the keyframe linear interpolator.
// Depends on kli_pkg, kli_ram and kli_div.
// A scan reads keys with a read state and a check state per key, and an insert shifts keys
// with a read state and a write state per key; a query may then start the serial divider
// and wait for it. Busy stays high until the result strobe.
// One beat at a time; the next beat can be taken in the strobe cycle. Reset clears the
// channel counts synchronously; key memories are not cleared. The receiver cannot stall.
module keyframe_linear_interpolator_unit
  import kli_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [3:0]         in_channel,
  input  logic [16:0]        in_step,
  input  logic signed [31:0] in_key_value,
  input  logic signed [31:0] in_default_value,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status,
  output logic [4:0]         out_key_count
);
  localparam int DEPTH = MAX_KEYS * NUM_CHANNELS;
  localparam int AW = $clog2(DEPTH);
  localparam int KW = $clog2(MAX_KEYS + 1);
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [KW-1:0] KMAX = KW'(MAX_KEYS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD = 4'd1;
  localparam logic [3:0] S_CHK = 4'd2;
  localparam logic [3:0] S_SHR = 4'd3;
  localparam logic [3:0] S_SHW = 4'd4;
  localparam logic [3:0] S_DIV = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;
  localparam logic [3:0] S_OUT = 4'd7;
  localparam logic [3:0] S_DWT = 4'd8;

  logic [3:0] state_r;
  logic [KW-1:0] counts_r [NUM_CHANNELS];
  logic [1:0] mode_r;
  logic [3:0] ch_r;
  logic [16:0] step_r;
  logic signed [31:0] kval_r, dval_r;
  logic [KW-1:0] cnt_r, idx_r;
  logic [16:0] sb_r;
  logic signed [31:0] vb_r;
  logic signed [31:0] res_r;
  logic [1:0] st_r;
  logic [4:0] kc_r;
  logic [AW-1:0] base;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [16:0] wstep, rstep;
  logic signed [31:0] wval, rval;
  logic div_start, div_done;
  logic signed [63:0] dividend, quotient;
  logic signed [32:0] vdiff;
  logic [16:0] sdiff;
  logic [17:0] divisor;
  logic [16:0] sa_r;
  logic signed [31:0] va_r;
  logic ch_ok;

  assign ch_ok = 32'(in_channel) < NUM_CHANNELS;
  assign base = AW'(32'(ch_r) * MAX_KEYS);
  assign busy = state_r != S_IDLE;

  kli_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_steps (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wstep), .raddr(raddr), .rdata(rstep));
  kli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vals (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wval), .raddr(raddr), .rdata(rval));

  assign vdiff = 33'(va_r) - 33'(vb_r);
  assign sdiff = step_r - sb_r;
  assign dividend = 64'(vdiff * $signed({1'b0, sdiff}));
  assign divisor = 18'({1'b0, sa_r} - {1'b0, sb_r});
  kli_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dividend),
    .divisor(divisor), .done(div_done), .quotient(quotient));

  always_comb begin
    raddr = base + AW'(idx_r);
    we = 1'b0;
    waddr = base + AW'(idx_r);
    wstep = step_r;
    wval = kval_r;
    div_start = 1'b0;
    if (state_r == S_SHR) raddr = base + AW'(idx_r - KW'(1));
    if (state_r == S_SHW) begin
      we = 1'b1;
      wstep = rstep;
      wval = rval;
    end
    if (state_r == S_CHK && mode_r == MODE_INSERT && idx_r < cnt_r &&
        rstep == step_r) we = 1'b1;
    if (state_r == S_SHR && idx_r == KW'(sa_r)) we = 1'b1;
    if (state_r == S_DIV) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) counts_r[i] <= '0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r <= in_mode;
            ch_r <= in_channel;
            kval_r <= in_key_value;
            dval_r <= in_default_value;
            idx_r <= '0;
            sb_r <= '0;
            vb_r <= in_default_value;
            res_r <= '0;
            st_r <= ST_OK;
            step_r <= (in_mode == MODE_QUERY && in_step > ONE_STEP) ? ONE_STEP : in_step;
            if (!ch_ok) begin
              kc_r <= '0;
              state_r <= S_OUT;
            end else begin
              cnt_r <= counts_r[in_channel[CW-1:0]];
              kc_r <= 5'(counts_r[in_channel[CW-1:0]]);
              if (in_step > ONE_STEP && in_mode != MODE_CLEAR && in_mode != MODE_NOP)
                st_r <= ST_RANGE;
              if (in_mode == MODE_CLEAR) begin
                counts_r[in_channel[CW-1:0]] <= '0;
                kc_r <= '0;
                state_r <= S_OUT;
              end else if (in_mode == MODE_INSERT && in_step > ONE_STEP) begin
                state_r <= S_OUT;
              end else if (in_mode == MODE_QUERY || in_mode == MODE_INSERT) begin
                state_r <= S_RD;
              end else begin
                state_r <= S_OUT;
              end
            end
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (mode_r == MODE_INSERT) begin
            if (idx_r < cnt_r && rstep < step_r) begin
              idx_r <= idx_r + KW'(1);
              state_r <= S_RD;
            end else if (idx_r < cnt_r && rstep == step_r) begin
              state_r <= S_OUT;
            end else if (cnt_r >= KMAX) begin
              st_r <= ST_FULL;
              state_r <= S_OUT;
            end else begin
              sa_r <= 17'(idx_r);
              idx_r <= cnt_r;
              state_r <= S_SHR;
            end
          end else begin
            if (cnt_r == 0) begin
              res_r <= dval_r;
              state_r <= S_OUT;
            end else if (idx_r < cnt_r && step_r >= rstep && step_r != ONE_STEP) begin
              sb_r <= rstep;
              vb_r <= rval;
              idx_r <= idx_r + KW'(1);
              state_r <= S_RD;
            end else if (idx_r < cnt_r && step_r != ONE_STEP) begin
              sa_r <= rstep;
              va_r <= rval;
              state_r <= S_DIV;
            end else begin
              idx_r <= cnt_r - KW'(1);
              sa_r <= ONE_STEP;
              state_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (sa_r == ONE_STEP && idx_r == cnt_r - KW'(1)) begin
            idx_r <= cnt_r;
          end else begin
            va_r <= rval;
            if (step_r == ONE_STEP) begin
              res_r <= rval;
              state_r <= S_OUT;
            end else state_r <= S_DIV;
          end
        end
        S_SHR: begin
          if (idx_r == KW'(sa_r)) begin
            cnt_r <= cnt_r + KW'(1);
            kc_r <= 5'(cnt_r + KW'(1));
            counts_r[ch_r[CW-1:0]] <= cnt_r + KW'(1);
            state_r <= S_OUT;
          end else state_r <= S_SHW;
        end
        S_SHW: begin
          idx_r <= idx_r - KW'(1);
          state_r <= S_SHR;
        end
        S_DIV: state_r <= S_DWT;
        S_DWT: begin
          if (div_done) state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_result_value <= res_r;
          out_status <= st_r;
          out_key_count <= kc_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_DWT && div_done) res_r <= 32'(64'(vb_r) + quotient);
    end
  end
endmodule

### hw/rtl/kli_ram.sv
// Generic simple dual-port synchronous RAM (one write port, one read port) with a registered read.
// No dependencies.
module kli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/kli_div.sv
// Serial restoring divider: 64-bit signed dividend by 18-bit positive divisor,
// quotient truncated toward zero, one bit a cycle. No dependencies.
module kli_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [17:0]        divisor,
  output logic               done,
  output logic signed [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [18:0] rem_r, rem_nxt;
  logic [17:0] d_r;
  logic neg_r;
  logic [6:0] cnt_r;
  logic run_r;
  logic [18:0] trial;
  always_comb begin
    trial = {rem_r[17:0], q_r[63]};
    if (trial >= {1'b0, d_r}) begin
      rem_nxt = trial - {1'b0, d_r};
      q_nxt = {q_r[62:0], 1'b1};
    end else begin
      rem_nxt = trial;
      q_nxt = {q_r[62:0], 1'b0};
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 7'd0;
        neg_r <= dividend[63];
        q_r <= dividend[63] ? 64'(-dividend) : dividend;
        rem_r <= '0;
        d_r <= divisor;
      end else if (run_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          run_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quotient = neg_r ? -q_r : q_r;
endmodule
